### rtl/mwsm_pkg.sv
// ----------------------------------------------------------------------------
// mwsm_pkg
// Shared constants and fixed-point helpers for the mecanum wheel speed mixer.
// ----------------------------------------------------------------------------
package mwsm_pkg;

   // register indexes on the csr port
   localparam logic [1:0] CSR_HALF_BASE_SUM        = 2'd0;
   localparam logic [1:0] CSR_INVERSE_WHEEL_RADIUS = 2'd1;
   localparam logic [1:0] CSR_MAX_WHEEL_SPEED      = 2'd2;

   // register reset values
   localparam logic [31:0] HALF_BASE_SUM_RESET        = 32'd0;
   localparam logic [31:0] INVERSE_WHEEL_RADIUS_RESET = 32'd65536;
   localparam logic [30:0] MAX_WHEEL_SPEED_RESET      = 31'd655360;

   // one quotient bit per divider stage, quotient is below 2^31
   localparam int DIV_STEPS = 31;
   localparam int WHEELS    = 4;

   // Q32.32 product to Q32.16, round half up (floor of (p + 2^15) / 2^16)
   function automatic logic signed [47:0] round_q16(input logic signed [63:0] p);
      logic signed [63:0] q;
      q = p + 64'sd32768;
      return q[63:16];
   endfunction

   // true when the value does not fit signed 32 bits
   function automatic logic clip32(input logic signed [47:0] v);
      return !((&v[47:31]) || !(|v[47:31]));
   endfunction

   // saturate to signed 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      logic signed [31:0] r;
      if (!clip32(v)) begin
         r = v[31:0];
      end else if (v[47]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7fff_ffff;
      end
      return r;
   endfunction

   // magnitude of a signed 32 bit value, 2^31 included
   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      return v[31] ? 32'(-v) : 32'(v);
   endfunction

endpackage

### rtl/mecanum_wheel_speed_mixer.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_speed_mixer
// Chassis velocity command to four mecanum wheel speeds with proportional
// speed limiting and saturation flag.
// ----------------------------------------------------------------------------
// One command is taken in every cycle (busy never rises) and its four wheel
// speeds appear on the rsp_ ports, marked by rsp_valid for one cycle, after
// the pipeline: seven stages of multiply, round, mix and maximum search, then
// a load stage and a 31-stage restoring divider for the limit/max scaling,
// then the output register. The receiver cannot stall; every beat must be
// taken when rsp_valid is high. Registers are to be written only while no
// command is in flight; the block itself does not enforce this.
module mecanum_wheel_speed_mixer (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_forward_speed,
   input  logic signed [31:0] req_lateral_speed,
   input  logic signed [31:0] req_yaw_rate,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_front_left_speed,
   output logic signed [31:0] rsp_front_right_speed,
   output logic signed [31:0] rsp_back_left_speed,
   output logic signed [31:0] rsp_back_right_speed,
   output logic               rsp_was_scaled,
   output logic               rsp_saturated,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_write_data
);

   localparam int NW = mwsm_pkg::WHEELS;
   localparam int ND = mwsm_pkg::DIV_STEPS;

   // configuration registers
   logic [31:0] half_base_sum_ff;
   logic [31:0] inverse_wheel_radius_ff;
   logic [30:0] max_wheel_speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_base_sum_ff        <= mwsm_pkg::HALF_BASE_SUM_RESET;
         inverse_wheel_radius_ff <= mwsm_pkg::INVERSE_WHEEL_RADIUS_RESET;
         max_wheel_speed_ff      <= mwsm_pkg::MAX_WHEEL_SPEED_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            mwsm_pkg::CSR_HALF_BASE_SUM:        half_base_sum_ff <= csr_write_data;
            mwsm_pkg::CSR_INVERSE_WHEEL_RADIUS: inverse_wheel_radius_ff <= csr_write_data;
            mwsm_pkg::CSR_MAX_WHEEL_SPEED:      max_wheel_speed_ff <= csr_write_data[30:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // pipeline registers
   logic               v0_ff, v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic signed [31:0] vx0_ff, vy0_ff, w0_ff;
   logic signed [31:0] vx1_ff, vy1_ff;
   logic signed [63:0] wp1_ff, wp1_in;
   logic signed [31:0] sum2_ff [NW];
   logic signed [31:0] sum2_in [NW];
   logic               clip2_ff, clip2_in;
   logic signed [63:0] prod3_ff [NW];
   logic signed [63:0] prod3_in [NW];
   logic               clip3_ff;
   logic signed [31:0] wheel4_ff [NW];
   logic signed [31:0] wheel4_in [NW];
   logic [31:0]        mag4_ff [NW];
   logic               clip4_ff, clip4_in;
   logic signed [31:0] wheel5_ff [NW];
   logic [31:0]        mag5_ff [NW];
   logic [31:0]        m5_ff, m5_in;
   logic               clip5_ff;
   logic signed [31:0] wheel6_ff [NW];
   logic [62:0]        num6_ff [NW];
   logic [31:0]        m6_ff;
   logic               scaled6_ff, clip6_ff;

   // divider stage registers, index 0 is the loaded numerator
   logic               dv_valid_ff  [ND+1];
   logic [31:0]        dv_rem_ff    [ND+1][NW];
   logic [30:0]        dv_num_ff    [ND+1][NW];
   logic [31:0]        dv_m_ff      [ND+1];
   logic               dv_scaled_ff [ND+1];
   logic               dv_clip_ff   [ND+1];
   logic signed [31:0] dv_wheel_ff  [ND+1][NW];

   // yaw product, wheel sums, radius products, round and saturate
   always_comb begin
      logic signed [31:0] wl;
      logic signed [33:0] s [NW];
      logic               c;
      wp1_in = 64'(w0_ff) * 64'(signed'({1'b0, half_base_sum_ff}));
      wl     = mwsm_pkg::sat32(mwsm_pkg::round_q16(wp1_ff));
      c      = mwsm_pkg::clip32(mwsm_pkg::round_q16(wp1_ff));
      s[0]   = 34'(vx1_ff) - 34'(vy1_ff) - 34'(wl);
      s[1]   = 34'(vx1_ff) + 34'(vy1_ff) + 34'(wl);
      s[2]   = 34'(vx1_ff) + 34'(vy1_ff) - 34'(wl);
      s[3]   = 34'(vx1_ff) - 34'(vy1_ff) + 34'(wl);
      for (int i = 0; i < NW; i++) begin
         sum2_in[i] = mwsm_pkg::sat32(48'(s[i]));
         c          = c | mwsm_pkg::clip32(48'(s[i]));
      end
      clip2_in = c;
      for (int i = 0; i < NW; i++) begin
         prod3_in[i] = 64'(sum2_ff[i]) * 64'(signed'({1'b0, inverse_wheel_radius_ff}));
      end
      clip4_in = clip3_ff;
      for (int i = 0; i < NW; i++) begin
         wheel4_in[i] = mwsm_pkg::sat32(mwsm_pkg::round_q16(prod3_ff[i]));
         clip4_in     = clip4_in | mwsm_pkg::clip32(mwsm_pkg::round_q16(prod3_ff[i]));
      end
   end

   // largest magnitude, two compare levels
   always_comb begin
      logic [31:0] a, b;
      a     = (mag4_ff[0] > mag4_ff[1]) ? mag4_ff[0] : mag4_ff[1];
      b     = (mag4_ff[2] > mag4_ff[3]) ? mag4_ff[2] : mag4_ff[3];
      m5_in = (a > b) ? a : b;
   end

   // front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v0_ff <= start & ~busy;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
      vx0_ff   <= req_forward_speed;
      vy0_ff   <= req_lateral_speed;
      w0_ff    <= req_yaw_rate;
      vx1_ff   <= vx0_ff;
      vy1_ff   <= vy0_ff;
      wp1_ff   <= wp1_in;
      sum2_ff  <= sum2_in;
      clip2_ff <= clip2_in;
      prod3_ff <= prod3_in;
      clip3_ff <= clip2_ff;
      clip4_ff <= clip4_in;
      for (int i = 0; i < NW; i++) begin
         wheel4_ff[i] <= wheel4_in[i];
         mag4_ff[i]   <= mwsm_pkg::mag32(wheel4_in[i]);
         wheel5_ff[i] <= wheel4_ff[i];
         mag5_ff[i]   <= mag4_ff[i];
         wheel6_ff[i] <= wheel5_ff[i];
         num6_ff[i]   <= 63'(mag5_ff[i]) * 63'(max_wheel_speed_ff);
      end
      m5_ff      <= m5_in;
      clip5_ff   <= clip4_ff;
      m6_ff      <= m5_ff;
      scaled6_ff <= m5_ff > {1'b0, max_wheel_speed_ff};
      clip6_ff   <= clip5_ff;
   end

   // divider load: add half the divisor for round to nearest
   always_ff @(posedge clock) begin
      logic [62:0] n;
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else begin
         dv_valid_ff[0] <= v6_ff;
      end
      for (int i = 0; i < NW; i++) begin
         n = num6_ff[i] + 63'(m6_ff >> 1);
         dv_rem_ff[0][i]   <= n[62:31];
         dv_num_ff[0][i]   <= n[30:0];
         dv_wheel_ff[0][i] <= wheel6_ff[i];
      end
      dv_m_ff[0]      <= m6_ff;
      dv_scaled_ff[0] <= scaled6_ff;
      dv_clip_ff[0]   <= clip6_ff;
   end

   // restoring divider, one quotient bit per stage shifted into the numerator
   for (genvar k = 1; k <= ND; k++) begin : g_div
      logic [31:0] rem_in [NW];
      logic [30:0] num_in [NW];

      always_comb begin
         logic [32:0] t;
         logic        ge;
         for (int i = 0; i < NW; i++) begin
            t         = {dv_rem_ff[k-1][i], dv_num_ff[k-1][i][30]};
            ge        = t >= {1'b0, dv_m_ff[k-1]};
            rem_in[i] = ge ? 32'(t - {1'b0, dv_m_ff[k-1]}) : t[31:0];
            num_in[i] = {dv_num_ff[k-1][i][29:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k] <= 1'b0;
         end else begin
            dv_valid_ff[k] <= dv_valid_ff[k-1];
         end
         dv_rem_ff[k]    <= rem_in;
         dv_num_ff[k]    <= num_in;
         dv_wheel_ff[k]  <= dv_wheel_ff[k-1];
         dv_m_ff[k]      <= dv_m_ff[k-1];
         dv_scaled_ff[k] <= dv_scaled_ff[k-1];
         dv_clip_ff[k]   <= dv_clip_ff[k-1];
      end
   end

   // output beat: scaled wheels take the quotient with the original sign
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_wheel_ff [NW];
   logic signed [31:0] rsp_wheel_in [NW];
   logic               rsp_scaled_ff, rsp_clip_ff;

   always_comb begin
      logic [31:0] q;
      for (int i = 0; i < NW; i++) begin
         q = {1'b0, dv_num_ff[ND][i]};
         if (dv_scaled_ff[ND]) begin
            rsp_wheel_in[i] = dv_wheel_ff[ND][i][31] ? signed'(32'(-q)) : signed'(q);
         end else begin
            rsp_wheel_in[i] = dv_wheel_ff[ND][i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid_ff[ND];
      end
      rsp_wheel_ff  <= rsp_wheel_in;
      rsp_scaled_ff <= dv_scaled_ff[ND];
      rsp_clip_ff   <= dv_clip_ff[ND];
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_front_left_speed  = rsp_wheel_ff[0];
   assign rsp_front_right_speed = rsp_wheel_ff[1];
   assign rsp_back_left_speed   = rsp_wheel_ff[2];
   assign rsp_back_right_speed  = rsp_wheel_ff[3];
   assign rsp_was_scaled        = rsp_scaled_ff;
   assign rsp_saturated         = rsp_clip_ff;

`ifndef SYNTHESIS
   // a scaled beat never exceeds the limit on any wheel
   a_scaled_within_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_scaled |->
         mwsm_pkg::mag32(rsp_front_left_speed) <= {1'b0, max_wheel_speed_ff} &&
         mwsm_pkg::mag32(rsp_front_right_speed) <= {1'b0, max_wheel_speed_ff} &&
         mwsm_pkg::mag32(rsp_back_left_speed) <= {1'b0, max_wheel_speed_ff} &&
         mwsm_pkg::mag32(rsp_back_right_speed) <= {1'b0, max_wheel_speed_ff})
      else $error("scaled wheel speed above limit");

   // divider remainder of wheels 0 and 3 stays below the divisor
   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      dv_valid_ff[ND] && dv_scaled_ff[ND] |->
         dv_rem_ff[ND][0] < dv_m_ff[ND] && dv_rem_ff[ND][3] < dv_m_ff[ND])
      else $error("divider remainder not below divisor");

   // scaling is only chosen for a nonzero maximum
   a_scale_nonzero: assert property (@(posedge clock) disable iff (reset)
      v6_ff && scaled6_ff |-> m6_ff != 32'd0)
      else $error("scaling with zero maximum");

   // reset empties the output
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("beat right after reset");
`endif

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives chassis velocity commands into the mecanum wheel speed mixer and
// compares every wheel speed beat with an in-bench fixed-point prediction.
// Directed corner commands come first, then random commands over several
// register settings, with random gaps between commands.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // expected wheel speeds of one command
   typedef struct {
      logic signed [31:0] fl, fr, bl, br;
      logic               scaled, clipped;
   } wheel_beat_type;

   // scoreboard: predicts wheel speeds and matches them in order
   class wheel_scoreboard;
      logic [31:0] half_base;
      logic [31:0] inv_radius;
      logic [30:0] speed_limit;
      wheel_beat_type pending[$];
      int          errors;

      function void set_reg(logic [1:0] idx, logic [31:0] data);
         if (idx == mwsm_pkg::CSR_HALF_BASE_SUM) half_base = data;
         else if (idx == mwsm_pkg::CSR_INVERSE_WHEEL_RADIUS) inv_radius = data;
         else if (idx == mwsm_pkg::CSR_MAX_WHEEL_SPEED) speed_limit = data[30:0];
      endfunction

      // floor((p + 2^15) / 2^16) then clip to signed 32 bits
      function longint round_clip(longint p, ref bit clip);
         longint q;
         q = (p + 64'sd32768) >>> 16;
         if (q > 64'sd2147483647) begin
            clip = 1;
            q = 64'sd2147483647;
         end else if (q < -64'sd2147483648) begin
            clip = 1;
            q = -64'sd2147483648;
         end
         return q;
      endfunction

      function void note_command(logic signed [31:0] vx, logic signed [31:0] vy,
                                 logic signed [31:0] w);
         longint      wl, s, peak, r;
         longint      sums[4];
         longint      wheel[4];
         longint      mag[4];
         bit          clip;
         wheel_beat_type b;
         clip = 0;
         peak = 0;
         wl = round_clip(longint'(w) * longint'({32'd0, half_base}), clip);
         sums[0] = longint'(vx) - vy - wl;
         sums[1] = longint'(vx) + vy + wl;
         sums[2] = longint'(vx) + vy - wl;
         sums[3] = longint'(vx) - vy + wl;
         for (int i = 0; i < 4; i++) begin
            s = round_clip(sums[i] <<< 16, clip);
            wheel[i] = round_clip(s * longint'({32'd0, inv_radius}), clip);
            mag[i] = wheel[i] < 0 ? -wheel[i] : wheel[i];
            if (mag[i] > peak) peak = mag[i];
         end
         b.scaled = peak > longint'(speed_limit);
         if (b.scaled) begin
            for (int i = 0; i < 4; i++) begin
               r = (mag[i] * longint'(speed_limit) + peak / 2) / peak;
               wheel[i] = wheel[i] < 0 ? -r : r;
            end
         end
         b.fl = wheel[0];
         b.fr = wheel[1];
         b.bl = wheel[2];
         b.br = wheel[3];
         b.clipped = clip;
         pending.push_back(b);
      endfunction

      function void check_beat(wheel_beat_type got);
         wheel_beat_type e;
         bit             bad;
         if (pending.size() == 0) begin
            $display("%0t: unexpected beat fl=%0d", $realtime, got.fl);
            errors++;
            return;
         end
         e = pending.pop_front();
         bad = 0;
         if (got.fl !== e.fl) begin
            $display("%0t: fl expected %0d got %0d", $realtime, e.fl, got.fl);
            bad = 1;
         end
         if (got.fr !== e.fr) begin
            $display("%0t: fr expected %0d got %0d", $realtime, e.fr, got.fr);
            bad = 1;
         end
         if (got.bl !== e.bl) begin
            $display("%0t: bl expected %0d got %0d", $realtime, e.bl, got.bl);
            bad = 1;
         end
         if (got.br !== e.br) begin
            $display("%0t: br expected %0d got %0d", $realtime, e.br, got.br);
            bad = 1;
         end
         if (got.scaled !== e.scaled) begin
            $display("%0t: scaled expected %0b got %0b", $realtime, e.scaled, got.scaled);
            bad = 1;
         end
         if (got.clipped !== e.clipped) begin
            $display("%0t: saturated expected %0b got %0b", $realtime,
                     e.clipped, got.clipped);
            bad = 1;
         end
         if (bad) errors++;
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic signed [31:0] req_forward_speed = 0;
   logic signed [31:0] req_lateral_speed = 0;
   logic signed [31:0] req_yaw_rate = 0;
   logic               rsp_valid;
   logic signed [31:0] rsp_front_left_speed, rsp_front_right_speed;
   logic signed [31:0] rsp_back_left_speed, rsp_back_right_speed;
   logic               rsp_was_scaled, rsp_saturated;
   logic               csr_write_enable = 0;
   logic [1:0]         csr_index = 0;
   logic [31:0]        csr_write_data = 0;

   wheel_scoreboard sb = new();

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   mecanum_wheel_speed_mixer DUT (.*);

   // result beats are taken at the rising edge
   always @(posedge clock) begin
      wheel_beat_type got;
      if (!reset && rsp_valid === 1'b1) begin
         got.fl = rsp_front_left_speed;
         got.fr = rsp_front_right_speed;
         got.bl = rsp_back_left_speed;
         got.br = rsp_back_right_speed;
         got.scaled = rsp_was_scaled;
         got.clipped = rsp_saturated;
         sb.check_beat(got);
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 0;
      sb.set_reg(idx, data);
   endtask

   // one command beat; start stays high across back-to-back beats
   task automatic send_command(logic signed [31:0] vx, logic signed [31:0] vy,
                               logic signed [31:0] w, int gap);
      start <= 1;
      req_forward_speed <= vx;
      req_lateral_speed <= vy;
      req_yaw_rate <= w;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_command(vx, vy, w);
      @(negedge clock);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 32'h0004_0000);
         2: return -$urandom_range(0, 32'h0004_0000);
         3: return 32'h7fff_ffff - $urandom_range(0, 3);
         4: return 32'h8000_0000 + $urandom_range(0, 3);
         default: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      endcase
   endfunction

   // called at a falling edge: drop start at once so no beat repeats
   task automatic drain();
      start <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   initial begin
      logic [31:0] corners[6];
      corners = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000,
                  32'hffff_0000, 32'h0000_8000};
      sb.half_base = mwsm_pkg::HALF_BASE_SUM_RESET;
      sb.inv_radius = mwsm_pkg::INVERSE_WHEEL_RADIUS_RESET;
      sb.speed_limit = mwsm_pkg::MAX_WHEEL_SPEED_RESET;
      sb.errors = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: reset registers, field extremes
      for (int i = 0; i < 6; i++)
         send_command(corners[i], corners[(i + 1) % 6], corners[(i + 3) % 6], i % 2);
      send_command(0, 0, 0, 0);
      send_command(32'h0003_0000, 32'hfffe_0000, 32'h0001_0000, 0);
      drain();
      // large half base and radius: saturation; zero limit
      write_reg(mwsm_pkg::CSR_HALF_BASE_SUM, 32'hffff_ffff);
      write_reg(mwsm_pkg::CSR_INVERSE_WHEEL_RADIUS, 32'hffff_ffff);
      write_reg(mwsm_pkg::CSR_MAX_WHEEL_SPEED, 32'h0);
      send_command(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0);
      send_command(32'h0001_0000, 0, 0, 0);
      send_command(0, 0, 0, 1);
      drain();
      // zero radius, max limit, bit above the limit width dropped
      write_reg(mwsm_pkg::CSR_INVERSE_WHEEL_RADIUS, 32'h0);
      write_reg(mwsm_pkg::CSR_MAX_WHEEL_SPEED, 32'hffff_ffff);
      write_reg(2'd3, 32'h1234_5678);
      send_command(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0);
      drain();
      write_reg(mwsm_pkg::CSR_INVERSE_WHEEL_RADIUS, 32'h0002_0000);
      send_command(32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000, 0);
      drain();

      // random phases with random register settings
      for (int p = 0; p < 8; p++) begin
         write_reg(mwsm_pkg::CSR_HALF_BASE_SUM, p == 7 ? 32'hffff_ffff :
                   ($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0002_0000)));
         write_reg(mwsm_pkg::CSR_INVERSE_WHEEL_RADIUS, p == 6 ? 32'h1 :
                   ($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 32'h0010_0000)));
         write_reg(mwsm_pkg::CSR_MAX_WHEEL_SPEED, p == 5 ? 32'h0 : p == 4 ? 32'h7fff_ffff :
                   ($urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0100_0000)));
         for (int n = 0; n < 75; n++)
            send_command(rand_word(), rand_word(), rand_word(),
                         p == 3 ? 0 : pick_gap());
         drain();
      end

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("CHECK FAILED");
      $finish;
   end
endmodule

### filelist.f
rtl/mwsm_pkg.sv
rtl/mecanum_wheel_speed_mixer.sv
verif/tb_top.sv
